// ----- rtl/tbpt_pkg.sv -----
package tbpt_pkg;

    // Parameter defaults
    localparam int MAX_CATCH_UP_DEF = 100;
    localparam int TIME_BITS_DEF    = 48;

    // Port widths
    localparam int NOW_W      = 48;
    localparam int OP_W       = 3;
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Field widths
    localparam int TALK_W     = 8;
    localparam int PHASE_W    = 2;
    localparam int REM_W      = 24;
    localparam int SEC_W      = 12;
    localparam int ALARM_W    = 16;
    localparam int TALK_LEN_W = 24;
    localparam int SEC_MS_W   = 22;
    localparam int MIN_SEC_W  = 14;

    // Output word bit positions
    localparam int OUT_CHANGED  = 0;
    localparam int OUT_RUNNING  = 1;
    localparam int OUT_PAUSED   = 2;
    localparam int OUT_PHASE_LO = 3;
    localparam int OUT_TALK_LO  = 5;
    localparam int OUT_REM_LO   = 13;
    localparam int OUT_WARN     = 37;

    // Time units
    localparam int MS_PER_SEC  = 1000;
    localparam int SEC_PER_MIN = 60;
    localparam int MS_PER_MIN  = MS_PER_SEC * SEC_PER_MIN;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TALK_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TALK_MINUTES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_SECONDS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_SECONDS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_MS      = 3'd4;

    // Register reset values
    localparam logic [TALK_W-1:0]  TALK_COUNT_RST    = 8'd5;
    localparam logic [TALK_W-1:0]  TALK_MINUTES_RST  = 8'd10;
    localparam logic [SEC_W-1:0]   WARN_SECONDS_RST  = 12'd60;
    localparam logic [SEC_W-1:0]   BREAK_SECONDS_RST = 12'd0;
    localparam logic [ALARM_W-1:0] ALARM_MS_RST      = 16'd3000;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_START    = 3'd1,
        OP_STOP     = 3'd2,
        OP_NEXT     = 3'd3,
        OP_RESTART  = 3'd4,
        OP_PREVIOUS = 3'd5,
        OP_PAUSE    = 3'd6,
        OP_RESUME   = 3'd7
    } op_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_TALK  = 2'd0,
        PH_ALARM = 2'd1,
        PH_BREAK = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CATCH,
        ST_REM,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic catch_step;
        logic calc_rem;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic tick_run;
        logic catch_go;
    } dp_sts_t;

endpackage

// ----- rtl/tbpt_ctrl.sv -----
module tbpt_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                m_tready,
    output logic                m_tvalid,
    input  tbpt_pkg::dp_sts_t   sts,
    output tbpt_pkg::ctrl_cmd_t cmd
);

    tbpt_pkg::state_t state_reg;
    tbpt_pkg::state_t state_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic             out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tbpt_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = tbpt_pkg::ST_EXEC;
                end
            end
            tbpt_pkg::ST_EXEC:
            begin
                state_next = sts.tick_run ? tbpt_pkg::ST_CATCH : tbpt_pkg::ST_REM;
            end
            tbpt_pkg::ST_CATCH:
            begin
                if (!sts.catch_go)
                begin
                    state_next = tbpt_pkg::ST_REM;
                end
            end
            tbpt_pkg::ST_REM:
            begin
                state_next = tbpt_pkg::ST_LOAD;
            end
            tbpt_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = tbpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tbpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        s_tready       = 1'b0;
        case (state_reg)
            tbpt_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            tbpt_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            tbpt_pkg::ST_CATCH:
            begin
                cmd.catch_step = sts.catch_go;
            end
            tbpt_pkg::ST_REM:
            begin
                cmd.calc_rem = 1'b1;
            end
            tbpt_pkg::ST_LOAD:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
        m_tvalid_next = cmd.load_out || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tbpt_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- rtl/tbpt_dp.sv -----
module tbpt_dp
#(
    parameter int MAX_CATCH_UP = tbpt_pkg::MAX_CATCH_UP_DEF,
    parameter int TIME_BITS    = tbpt_pkg::TIME_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tbpt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbpt_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [tbpt_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [tbpt_pkg::S_TUSER_W-1:0]      s_tuser,
    input  tbpt_pkg::ctrl_cmd_t                 cmd,
    output tbpt_pkg::dp_sts_t                   sts,
    output logic [tbpt_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int GUARD_W = $clog2(MAX_CATCH_UP + 1);
    localparam int REM_W   = tbpt_pkg::REM_W;
    localparam int TALK_W  = tbpt_pkg::TALK_W;

    // Config registers and derived phase lengths
    logic [TALK_W-1:0]               talk_count_reg;
    logic [TALK_W-1:0]               talk_minutes_reg;
    logic [tbpt_pkg::SEC_W-1:0]      warn_seconds_reg;
    logic [tbpt_pkg::SEC_W-1:0]      break_seconds_reg;
    logic [tbpt_pkg::ALARM_W-1:0]    alarm_ms_reg;
    logic [tbpt_pkg::TALK_LEN_W-1:0] talk_len_reg;
    logic [tbpt_pkg::SEC_MS_W-1:0]   break_len_reg;
    logic [tbpt_pkg::SEC_MS_W-1:0]   warn_ms_reg;
    logic                            warn_en_reg;

    // Session state
    logic                   active_reg;
    logic                   held_reg;
    tbpt_pkg::phase_t       phase_reg;
    logic [TALK_W-1:0]      talk_reg;
    logic [TIME_BITS-1:0]   end_reg;
    logic [TIME_BITS-1:0]   held_since_reg;
    logic                   changed_reg;
    logic [GUARD_W-1:0]     guard_reg;

    // Per-word payload
    tbpt_pkg::op_t          op_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic [TIME_BITS-1:0]   delta_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [tbpt_pkg::M_TDATA_W-1:0] out_reg;

    logic [TIME_BITS+tbpt_pkg::NOW_W-1:0] now_wide;
    logic [TIME_BITS-1:0]   now_in;
    logic [TIME_BITS-1:0]   delta_in;

    logic                   is_last;
    logic                   brk_on;
    logic                   adv;
    logic                   skipped;
    logic                   do_enter;
    logic                   do_stop;
    logic                   set_hold;
    logic                   do_resume;
    tbpt_pkg::phase_t       ent_ph;
    logic [TALK_W-1:0]      ent_talk;
    logic [TIME_BITS-1:0]   ent_at;
    logic [REM_W-1:0]       len;
    logic [TIME_BITS-1:0]   add_a;
    logic [TIME_BITS-1:0]   add_b;
    logic [TIME_BITS:0]     sum;
    logic [TIME_BITS-1:0]   new_end;

    logic [TIME_BITS-1:0]   rem_ref;
    logic [TIME_BITS-1:0]   rem_diff;
    logic [REM_W-1:0]       rem_next;
    logic                   warn;

    // Time is masked to TIME_BITS, zero-extended when wider than the port.
    assign now_wide = {{TIME_BITS{1'b0}}, s_tdata};
    assign now_in   = now_wide[TIME_BITS-1:0];
    assign delta_in = (now_in > held_since_reg) ? (now_in - held_since_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            talk_count_reg    <= tbpt_pkg::TALK_COUNT_RST;
            talk_minutes_reg  <= tbpt_pkg::TALK_MINUTES_RST;
            warn_seconds_reg  <= tbpt_pkg::WARN_SECONDS_RST;
            break_seconds_reg <= tbpt_pkg::BREAK_SECONDS_RST;
            alarm_ms_reg      <= tbpt_pkg::ALARM_MS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tbpt_pkg::REG_TALK_COUNT:    talk_count_reg    <= cfg_data[TALK_W-1:0];
                tbpt_pkg::REG_TALK_MINUTES:  talk_minutes_reg  <= cfg_data[TALK_W-1:0];
                tbpt_pkg::REG_WARN_SECONDS:  warn_seconds_reg  <= cfg_data[tbpt_pkg::SEC_W-1:0];
                tbpt_pkg::REG_BREAK_SECONDS: break_seconds_reg <= cfg_data[tbpt_pkg::SEC_W-1:0];
                tbpt_pkg::REG_ALARM_MS:      alarm_ms_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Lengths in ms; constant multipliers, one register stage behind config.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            talk_len_reg  <= tbpt_pkg::TALK_LEN_W'(int'(tbpt_pkg::TALK_MINUTES_RST)
                             * tbpt_pkg::MS_PER_MIN);
            break_len_reg <= '0;
            warn_ms_reg   <= tbpt_pkg::SEC_MS_W'(int'(tbpt_pkg::WARN_SECONDS_RST)
                             * tbpt_pkg::MS_PER_SEC);
            warn_en_reg   <= 1'b1;
        end
        else
        begin
            talk_len_reg  <= tbpt_pkg::TALK_LEN_W'(talk_minutes_reg)
                             * tbpt_pkg::TALK_LEN_W'(tbpt_pkg::MS_PER_MIN);
            break_len_reg <= tbpt_pkg::SEC_MS_W'(break_seconds_reg)
                             * tbpt_pkg::SEC_MS_W'(tbpt_pkg::MS_PER_SEC);
            warn_ms_reg   <= tbpt_pkg::SEC_MS_W'(warn_seconds_reg)
                             * tbpt_pkg::SEC_MS_W'(tbpt_pkg::MS_PER_SEC);
            // window shorter than the talk: compared in seconds
            warn_en_reg   <= (warn_seconds_reg != '0)
                             && (tbpt_pkg::MIN_SEC_W'(warn_seconds_reg)
                                 < tbpt_pkg::MIN_SEC_W'(talk_minutes_reg)
                                   * tbpt_pkg::MIN_SEC_W'(tbpt_pkg::SEC_PER_MIN));
        end
    end

    // Command decode and phase sequencing
    assign is_last = ({1'b0, talk_reg} + 9'd1) >= {1'b0, talk_count_reg};
    assign brk_on  = (break_seconds_reg != '0);
    assign skipped = !cmd.catch_step;
    assign adv     = cmd.catch_step
                     || (cmd.exec && (op_reg == tbpt_pkg::OP_NEXT) && active_reg);

    always_comb
    begin
        do_enter  = 1'b0;
        do_stop   = 1'b0;
        set_hold  = 1'b0;
        do_resume = 1'b0;
        ent_ph    = tbpt_pkg::PH_TALK;
        ent_talk  = talk_reg;
        ent_at    = cmd.catch_step ? end_reg : now_reg;

        if (adv)
        begin
            if (phase_reg == tbpt_pkg::PH_BREAK)
            begin
                do_enter = 1'b1;
                ent_talk = talk_reg + 8'd1;
            end
            else if ((phase_reg == tbpt_pkg::PH_TALK) && !skipped)
            begin
                do_enter = 1'b1;
                ent_ph   = tbpt_pkg::PH_ALARM;
            end
            else if (is_last)
            begin
                do_stop = 1'b1;
            end
            else if (brk_on)
            begin
                do_enter = 1'b1;
                ent_ph   = tbpt_pkg::PH_BREAK;
            end
            else
            begin
                do_enter = 1'b1;
                ent_talk = talk_reg + 8'd1;
            end
        end
        else if (cmd.exec)
        begin
            case (op_reg)
                tbpt_pkg::OP_START:
                begin
                    do_enter = 1'b1;
                    ent_talk = '0;
                end
                tbpt_pkg::OP_STOP:
                begin
                    do_stop = 1'b1;
                end
                tbpt_pkg::OP_RESTART:
                begin
                    do_enter = active_reg;
                    ent_ph   = (phase_reg == tbpt_pkg::PH_BREAK) ? tbpt_pkg::PH_BREAK
                                                                 : tbpt_pkg::PH_TALK;
                end
                tbpt_pkg::OP_PREVIOUS:
                begin
                    do_enter = active_reg;
                    if (phase_reg == tbpt_pkg::PH_BREAK)
                    begin
                        ent_talk = talk_reg;
                    end
                    else if (talk_reg == '0)
                    begin
                        ent_talk = '0;
                    end
                    else
                    begin
                        ent_talk = talk_reg - 8'd1;
                        ent_ph   = brk_on ? tbpt_pkg::PH_BREAK : tbpt_pkg::PH_TALK;
                    end
                end
                tbpt_pkg::OP_PAUSE:
                begin
                    set_hold = active_reg && !held_reg;
                end
                tbpt_pkg::OP_RESUME:
                begin
                    do_resume = active_reg && held_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // One shared saturating adder for phase entry and resume
    always_comb
    begin
        case (ent_ph)
            tbpt_pkg::PH_ALARM: len = REM_W'(alarm_ms_reg);
            tbpt_pkg::PH_BREAK: len = REM_W'(break_len_reg);
            default:            len = talk_len_reg;
        endcase
        add_a   = do_resume ? end_reg : ent_at;
        add_b   = do_resume ? delta_reg : {{(TIME_BITS-REM_W){1'b0}}, len};
        sum     = {1'b0, add_a} + {1'b0, add_b};
        new_end = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            held_reg       <= 1'b0;
            phase_reg      <= tbpt_pkg::PH_TALK;
            talk_reg       <= '0;
            end_reg        <= '0;
            held_since_reg <= '0;
            changed_reg    <= 1'b0;
            guard_reg      <= '0;
        end
        else
        begin
            if (do_enter)
            begin
                active_reg <= 1'b1;
                held_reg   <= 1'b0;
                phase_reg  <= ent_ph;
                talk_reg   <= ent_talk;
                end_reg    <= new_end;
            end
            else if (do_stop)
            begin
                active_reg <= 1'b0;
                held_reg   <= 1'b0;
            end
            else if (set_hold)
            begin
                held_reg       <= 1'b1;
                held_since_reg <= now_reg;
            end
            else if (do_resume)
            begin
                held_reg <= 1'b0;
                end_reg  <= new_end;
            end

            if (cmd.load_in)
            begin
                changed_reg <= 1'b0;
            end
            else if (cmd.catch_step)
            begin
                changed_reg <= 1'b1;
            end

            if (cmd.exec)
            begin
                guard_reg <= '0;
            end
            else if (cmd.catch_step)
            begin
                guard_reg <= guard_reg + GUARD_W'(1);
            end
        end
    end

    assign sts.tick_run = (op_reg == tbpt_pkg::OP_TICK) && active_reg && !held_reg;
    assign sts.catch_go = active_reg && (now_reg >= end_reg)
                          && (guard_reg < GUARD_W'(MAX_CATCH_UP));

    // Remaining time against the pause time while held
    always_comb
    begin
        rem_ref  = held_reg ? held_since_reg : now_reg;
        rem_diff = end_reg - rem_ref;
        if (!active_reg || (end_reg <= rem_ref))
        begin
            rem_next = '0;
        end
        else if (|rem_diff[TIME_BITS-1:REM_W])
        begin
            rem_next = '1;
        end
        else
        begin
            rem_next = rem_diff[REM_W-1:0];
        end
    end

    assign warn = active_reg && (phase_reg == tbpt_pkg::PH_TALK) && warn_en_reg
                  && (rem_reg <= REM_W'(warn_ms_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= tbpt_pkg::op_t'(s_tuser);
            now_reg   <= now_in;
            delta_reg <= delta_in;
        end
        if (cmd.calc_rem)
        begin
            rem_reg <= rem_next;
        end
        if (cmd.load_out)
        begin
            out_reg <= {2'b00, warn, rem_reg, talk_reg, phase_reg,
                        held_reg, active_reg, changed_reg};
        end
    end

    assign m_tdata = out_reg;

endmodule

// ----- rtl/talk_break_phase_timer.sv -----
// Talk/break phase timer. Each input word is a command (tick, start, stop,
// next, restart, previous, pause, resume) stamped with the current time in
// ms; each command returns exactly one status word. A session runs
// talk_count talks; an expired talk enters an alarm phase of alarm_ms, then a
// break of break_seconds (skipped when zero) or the next talk, and ends after
// the last talk. A tick walks through every phase whose end has passed, one
// phase per clock on the shared end-time adder, at most MAX_CATCH_UP phases,
// each new phase starting at the previous end. Pause freezes the remaining
// time; resume pushes the phase end out by the time held. A command passes
// through accept, execute, remaining-time compute and output load; a tick
// on a running, unpaused session also makes one catch-up step per phase it
// advances, between execute and remaining-time compute, on that adder. The
// next command is taken as soon as the status word sits in the output
// register, even if the sink has not yet taken it. Config writes go straight
// into the registers and must only be made while no command is in flight.
module talk_break_phase_timer
#(
    parameter int MAX_CATCH_UP = tbpt_pkg::MAX_CATCH_UP_DEF,  // 1..255
    parameter int TIME_BITS    = tbpt_pkg::TIME_BITS_DEF      // 32..64
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    // Config: 0 talk_count, 1 talk_minutes, 2 warn_seconds,
    // 3 break_seconds, 4 alarm_ms; other indexes ignored
    input  logic                            cfg_we,
    input  logic [tbpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbpt_pkg::CFG_DATA_W-1:0] cfg_data,

    // Command stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tbpt_pkg::S_TDATA_W-1:0]  s_tdata,   // [47:0] now
    input  logic [tbpt_pkg::S_TUSER_W-1:0]  s_tuser,   // [2:0] op

    // Status stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] changed, [1] running, [2] is_paused, [4:3] phase,
    // [12:5] talk number, [36:13] ms left, [37] warn, [39:38] zero
    output logic [tbpt_pkg::M_TDATA_W-1:0]  m_tdata
);

    tbpt_pkg::ctrl_cmd_t cmd;
    tbpt_pkg::dp_sts_t   sts;

    // Sequencer: accept, execute, catch-up loop, status build, output handoff
    tbpt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Config, session state, end-time adder, remaining/warn, output register
    tbpt_dp
    #(
        .MAX_CATCH_UP (MAX_CATCH_UP),
        .TIME_BITS    (TIME_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- rtl/tbpt_chk.sv -----
module tbpt_chk
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tbpt_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic                   running;
    logic                   paused;
    logic                   warn;
    logic [1:0]             phase;
    logic [tbpt_pkg::REM_W-1:0] rem;

    assign running = m_tdata[tbpt_pkg::OUT_RUNNING];
    assign paused  = m_tdata[tbpt_pkg::OUT_PAUSED];
    assign warn    = m_tdata[tbpt_pkg::OUT_WARN];
    assign phase   = m_tdata[tbpt_pkg::OUT_PHASE_LO +: 2];
    assign rem     = m_tdata[tbpt_pkg::OUT_REM_LO +: tbpt_pkg::REM_W];

    // stalled status word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("status word changed under stall");

    // a stopped session reports no time left, no warning and no pause
    a_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !running |-> (rem == '0) && !warn && !paused)
        else $error("stopped session shows time, warning or pause");

    // warning only in a running talk phase
    a_warn_talk: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && warn |-> running && (phase == tbpt_pkg::PH_TALK))
        else $error("warning outside a running talk");

    // phase code stays within talk, alarm and break
    a_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (phase == tbpt_pkg::PH_TALK) || (phase == tbpt_pkg::PH_ALARM)
                     || (phase == tbpt_pkg::PH_BREAK))
        else $error("phase code out of range");

endmodule

bind talk_break_phase_timer tbpt_chk u_tbpt_chk (.*);

// ----- test/tb_talk_break_phase_timer.sv -----
`timescale 1ns / 100ps

module tb_talk_break_phase_timer;

    // Catch-up bound of the instance (default parameters)
    localparam int CATCH_LIMIT = tbpt_pkg::MAX_CATCH_UP_DEF;

    // Slowest legal word: the longest sender gap, a full catch-up run of
    // CATCH_LIMIT phases and the longest sink stall. About 1200 commands in
    // all, so LIMIT_CYCLES leaves several times the margin.
    localparam int LIMIT_CYCLES = 1_000_000;

    // Commands per random run
    localparam int PHASE_WORDS = 117;

    localparam logic [tbpt_pkg::NOW_W-1:0] NOW_MAX = '1;

    typedef struct packed {
        tbpt_pkg::op_t              op;
        logic [tbpt_pkg::NOW_W-1:0] now;
    } cmd_t;

    // Same layout as m_tdata, lowest field last
    typedef struct packed {
        logic [1:0]                  pad;
        logic                        warn;
        logic [tbpt_pkg::REM_W-1:0]  rem;
        logic [tbpt_pkg::TALK_W-1:0] talk;
        tbpt_pkg::phase_t            phase;
        logic                        paused;
        logic                        running;
        logic                        changed;
    } status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            cfg_we = 1'b0;
    logic [tbpt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tbpt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [tbpt_pkg::S_TDATA_W-1:0]  s_tdata = '0;   // [47:0] now
    logic [tbpt_pkg::S_TUSER_W-1:0]  s_tuser = '0;   // [2:0] op

    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // [0] changed, [1] running, [2] is_paused, [4:3] phase,
    // [12:5] talk number, [36:13] ms left, [37] warn, [39:38] zero
    logic [tbpt_pkg::M_TDATA_W-1:0]  m_tdata;

    talk_break_phase_timer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the timer: config registers and session state
    // ------------------------------------------------------------------
    logic [tbpt_pkg::TALK_W-1:0]  cfg_talks   = tbpt_pkg::TALK_COUNT_RST;
    logic [tbpt_pkg::TALK_W-1:0]  cfg_minutes = tbpt_pkg::TALK_MINUTES_RST;
    logic [tbpt_pkg::SEC_W-1:0]   cfg_warn    = tbpt_pkg::WARN_SECONDS_RST;
    logic [tbpt_pkg::SEC_W-1:0]   cfg_break   = tbpt_pkg::BREAK_SECONDS_RST;
    logic [tbpt_pkg::ALARM_W-1:0] cfg_alarm   = tbpt_pkg::ALARM_MS_RST;

    logic                        tmr_active = 1'b0;
    logic                        tmr_held = 1'b0;
    tbpt_pkg::phase_t            tmr_phase = tbpt_pkg::PH_TALK;
    logic [tbpt_pkg::TALK_W-1:0] tmr_talk = '0;
    logic [tbpt_pkg::NOW_W-1:0]  tmr_end = '0;
    logic [tbpt_pkg::NOW_W-1:0]  tmr_held_since = '0;

    cmd_t    cmd_backlog[$];     // commands waiting for the driver
    status_t status_due[$];      // predicted status words, oldest first

    int unsigned words_seen = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    logic [tbpt_pkg::NOW_W-1:0] stim_ms = '0;

    // Phase end, pinned at the top of the time range
    function automatic logic [tbpt_pkg::NOW_W-1:0] end_after(
        input logic [tbpt_pkg::NOW_W-1:0] at,
        input logic [tbpt_pkg::NOW_W-1:0] len);
        logic [tbpt_pkg::NOW_W:0] sum;
        sum = {1'b0, at} + {1'b0, len};
        return sum[tbpt_pkg::NOW_W] ? NOW_MAX : sum[tbpt_pkg::NOW_W-1:0];
    endfunction

    function automatic logic [tbpt_pkg::NOW_W-1:0] phase_ms(input tbpt_pkg::phase_t ph);
        case (ph)
            tbpt_pkg::PH_ALARM: return tbpt_pkg::NOW_W'(cfg_alarm);
            tbpt_pkg::PH_BREAK: return tbpt_pkg::NOW_W'(cfg_break) * tbpt_pkg::MS_PER_SEC;
            default:            return tbpt_pkg::NOW_W'(cfg_minutes) * tbpt_pkg::MS_PER_MIN;
        endcase
    endfunction

    function automatic void enter_phase(input tbpt_pkg::phase_t ph,
                                        input logic [tbpt_pkg::TALK_W-1:0] talk,
                                        input logic [tbpt_pkg::NOW_W-1:0] at);
        tmr_active = 1'b1;
        tmr_held   = 1'b0;
        tmr_phase  = ph;
        tmr_talk   = talk;
        tmr_end    = end_after(at, phase_ms(ph));
    endfunction

    // skipped: next command, a talk goes on without its alarm
    function automatic void advance_phase(input logic [tbpt_pkg::NOW_W-1:0] at,
                                          input logic skipped);
        if (tmr_phase == tbpt_pkg::PH_BREAK)
            enter_phase(tbpt_pkg::PH_TALK, tmr_talk + 8'd1, at);
        else if (tmr_phase == tbpt_pkg::PH_TALK && !skipped)
            enter_phase(tbpt_pkg::PH_ALARM, tmr_talk, at);
        else if (({1'b0, tmr_talk} + 9'd1) >= {1'b0, cfg_talks})
        begin
            tmr_active = 1'b0;
            tmr_held   = 1'b0;
        end
        else if (cfg_break != 0)
            enter_phase(tbpt_pkg::PH_BREAK, tmr_talk, at);
        else
            enter_phase(tbpt_pkg::PH_TALK, tmr_talk + 8'd1, at);
    endfunction

    function automatic logic [tbpt_pkg::REM_W-1:0] ms_left(
        input logic [tbpt_pkg::NOW_W-1:0] now);
        logic [tbpt_pkg::NOW_W-1:0] from_ms;
        logic [tbpt_pkg::NOW_W-1:0] diff;
        if (!tmr_active)
            return '0;
        from_ms = tmr_held ? tmr_held_since : now;
        diff = (tmr_end > from_ms) ? tmr_end - from_ms : '0;
        return (diff > tbpt_pkg::NOW_W'({tbpt_pkg::REM_W{1'b1}})) ? {tbpt_pkg::REM_W{1'b1}}
                                                                  : diff[tbpt_pkg::REM_W-1:0];
    endfunction

    function automatic logic warn_due(input logic [tbpt_pkg::NOW_W-1:0] now);
        logic [tbpt_pkg::NOW_W-1:0] window;
        if (!tmr_active || tmr_phase != tbpt_pkg::PH_TALK || cfg_warn == 0)
            return 1'b0;
        window = tbpt_pkg::NOW_W'(cfg_warn) * tbpt_pkg::MS_PER_SEC;
        // window covering the whole talk disables the warning
        if (window >= phase_ms(tbpt_pkg::PH_TALK))
            return 1'b0;
        return tbpt_pkg::NOW_W'(ms_left(now)) <= window;
    endfunction

    // Applies one command to the shadow state, returns the status word
    function automatic status_t next_status(input tbpt_pkg::op_t op,
                                            input logic [tbpt_pkg::NOW_W-1:0] now);
        status_t st;
        logic [tbpt_pkg::NOW_W-1:0] held_ms;
        int guard;
        st = '0;
        case (op)
            tbpt_pkg::OP_TICK:
                if (tmr_active && !tmr_held)
                    for (guard = 0; guard < CATCH_LIMIT && tmr_active && now >= tmr_end;
                         guard++)
                    begin
                        advance_phase(tmr_end, 1'b0);
                        st.changed = 1'b1;
                    end
            tbpt_pkg::OP_START:
                enter_phase(tbpt_pkg::PH_TALK, '0, now);
            tbpt_pkg::OP_STOP:
            begin
                tmr_active = 1'b0;
                tmr_held   = 1'b0;
            end
            tbpt_pkg::OP_NEXT:
                if (tmr_active)
                begin
                    tmr_held = 1'b0;
                    advance_phase(now, 1'b1);
                end
            tbpt_pkg::OP_RESTART:
                if (tmr_active)
                    enter_phase((tmr_phase == tbpt_pkg::PH_BREAK) ? tbpt_pkg::PH_BREAK
                                                                  : tbpt_pkg::PH_TALK,
                                tmr_talk, now);
            tbpt_pkg::OP_PREVIOUS:
                if (tmr_active)
                begin
                    if (tmr_phase == tbpt_pkg::PH_BREAK)
                        enter_phase(tbpt_pkg::PH_TALK, tmr_talk, now);
                    else if (tmr_talk == 0)
                        enter_phase(tbpt_pkg::PH_TALK, '0, now);
                    else if (cfg_break != 0)
                        enter_phase(tbpt_pkg::PH_BREAK, tmr_talk - 8'd1, now);
                    else
                        enter_phase(tbpt_pkg::PH_TALK, tmr_talk - 8'd1, now);
                end
            tbpt_pkg::OP_PAUSE:
                if (tmr_active && !tmr_held)
                begin
                    tmr_held = 1'b1;
                    tmr_held_since = now;
                end
            default:  // resume; a clock that went backwards counts as no time held
                if (tmr_active && tmr_held)
                begin
                    held_ms = (now > tmr_held_since) ? now - tmr_held_since : '0;
                    tmr_end = end_after(tmr_end, held_ms);
                    tmr_held = 1'b0;
                end
        endcase
        st.running = tmr_active;
        st.paused  = tmr_held;
        st.phase   = tmr_phase;
        st.talk    = tmr_talk;
        st.rem     = ms_left(now);
        st.warn    = warn_due(now);
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of random length, random gaps, now and then a full
    // drain where it holds off until every status word is back
    // ------------------------------------------------------------------
    int unsigned burst_left = 1;
    int unsigned hold_gap = 0;
    logic        drain_hold = 1'b0;

    always @(posedge clk)
    begin : feed
        cmd_t nxt;
        logic took;
        took = s_tvalid && s_tready;
        if (took)
            status_due.push_back(next_status(tbpt_pkg::op_t'(s_tuser), s_tdata));
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || took)
        begin
            if (hold_gap > 0)
            begin
                hold_gap--;
                s_tvalid <= 1'b0;
            end
            else if (drain_hold && status_due.size() != 0)
                s_tvalid <= 1'b0;
            else if (cmd_backlog.size() == 0)
                s_tvalid <= 1'b0;
            else
            begin
                drain_hold = 1'b0;
                nxt = cmd_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.op;
                s_tdata  <= nxt.now;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    hold_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
                    drain_hold = ($urandom_range(0, 19) == 0);
                end
                else
                    burst_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sink stalls follow a 16-bit mask that is reloaded now and
    // then (all ready, random, mostly stalled, one long stall)
    // ------------------------------------------------------------------
    logic [15:0] stall_mask = 16'hFFFF;
    logic [3:0]  stall_pos = '0;

    task automatic flag_error(input string msg);
        err_count++;
        $display("%t mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [tbpt_pkg::NOW_W-1:0] got,
                               input logic [tbpt_pkg::NOW_W-1:0] want);
        if (got !== want)
            flag_error($sformatf("word %0d %s got %0h want %0h", words_seen, name, got, want));
    endtask

    always @(posedge clk)
    begin : observe
        status_t got;
        status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            words_seen++;
            if (status_due.size() == 0)
                flag_error($sformatf("word %0d arrived with nothing expected", words_seen));
            else
            begin
                want = status_due.pop_front();
                check_field("changed", tbpt_pkg::NOW_W'(got.changed),
                            tbpt_pkg::NOW_W'(want.changed));
                check_field("running", tbpt_pkg::NOW_W'(got.running),
                            tbpt_pkg::NOW_W'(want.running));
                check_field("is_paused", tbpt_pkg::NOW_W'(got.paused),
                            tbpt_pkg::NOW_W'(want.paused));
                check_field("phase", tbpt_pkg::NOW_W'(got.phase),
                            tbpt_pkg::NOW_W'(want.phase));
                check_field("talk", tbpt_pkg::NOW_W'(got.talk),
                            tbpt_pkg::NOW_W'(want.talk));
                check_field("time left", tbpt_pkg::NOW_W'(got.rem),
                            tbpt_pkg::NOW_W'(want.rem));
                check_field("warn", tbpt_pkg::NOW_W'(got.warn),
                            tbpt_pkg::NOW_W'(want.warn));
            end
        end
        stall_pos <= stall_pos + 4'd1;
        m_tready  <= stall_mask[stall_pos];
        if (stall_pos == 4'hF && $urandom_range(0, 3) == 0)
            case ($urandom_range(0, 3))
                0:       stall_mask <= 16'hFFFF;
                1:       stall_mask <= 16'($urandom) | 16'h0001;
                2:       stall_mask <= (16'($urandom) & 16'($urandom)) | 16'h0001;
                default: stall_mask <= 16'h8000;
            endcase
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("[talk_break_phase_timer] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_cmd(input tbpt_pkg::op_t op, input logic [tbpt_pkg::NOW_W-1:0] now);
        cmd_t c;
        c.op  = op;
        c.now = now;
        cmd_backlog.push_back(c);
    endtask

    // Block is quiet: nothing queued, nothing offered, nothing owed;
    // sampled away from the driving edge
    task automatic wait_idle();
        @(negedge clk);
        while (cmd_backlog.size() != 0 || s_tvalid || status_due.size() != 0)
            @(negedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Shadow keeps only the bits the register holds
    task automatic write_reg(input logic [tbpt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tbpt_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            tbpt_pkg::REG_TALK_COUNT:    cfg_talks   = data[tbpt_pkg::TALK_W-1:0];
            tbpt_pkg::REG_TALK_MINUTES:  cfg_minutes = data[tbpt_pkg::TALK_W-1:0];
            tbpt_pkg::REG_WARN_SECONDS:  cfg_warn    = data[tbpt_pkg::SEC_W-1:0];
            tbpt_pkg::REG_BREAK_SECONDS: cfg_break   = data[tbpt_pkg::SEC_W-1:0];
            tbpt_pkg::REG_ALARM_MS:      cfg_alarm   = data[tbpt_pkg::ALARM_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int talks, input int minutes, input int warn_s,
                              input int break_s, input int alarm);
        write_reg(tbpt_pkg::REG_TALK_COUNT, tbpt_pkg::CFG_DATA_W'(talks));
        write_reg(tbpt_pkg::REG_TALK_MINUTES, tbpt_pkg::CFG_DATA_W'(minutes));
        write_reg(tbpt_pkg::REG_WARN_SECONDS, tbpt_pkg::CFG_DATA_W'(warn_s));
        write_reg(tbpt_pkg::REG_BREAK_SECONDS, tbpt_pkg::CFG_DATA_W'(break_s));
        write_reg(tbpt_pkg::REG_ALARM_MS, tbpt_pkg::CFG_DATA_W'(alarm));
    endtask

    // Mostly sessions in motion: time steps land on phase ends, warning
    // edges and multi-phase jumps; a few backward, near-top and wild times.
    task automatic queue_random_words(input int n);
        cmd_t c;
        logic [tbpt_pkg::NOW_W-1:0] talk_len;
        logic [tbpt_pkg::NOW_W-1:0] window;
        logic [tbpt_pkg::NOW_W-1:0] back;
        int pick;
        repeat (n)
        begin
            talk_len = phase_ms(tbpt_pkg::PH_TALK);
            window   = tbpt_pkg::NOW_W'(cfg_warn) * tbpt_pkg::MS_PER_SEC;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                c.op = tbpt_pkg::OP_START;
            else if (pick < 7)
                c.op = tbpt_pkg::OP_STOP;
            else if (pick < 55)
                c.op = tbpt_pkg::OP_TICK;
            else if (pick < 63)
                c.op = tbpt_pkg::OP_PAUSE;
            else if (pick < 72)
                c.op = tbpt_pkg::OP_RESUME;
            else if (pick < 80)
                c.op = tbpt_pkg::OP_NEXT;
            else if (pick < 88)
                c.op = tbpt_pkg::OP_PREVIOUS;
            else if (pick < 94)
                c.op = tbpt_pkg::OP_RESTART;
            else
                c.op = tbpt_pkg::OP_TICK;

            pick = $urandom_range(0, 99);
            if (pick < 30)
                stim_ms += phase_ms(tbpt_pkg::phase_t'(2'($urandom_range(0, 2))));
            else if (pick < 50)
                stim_ms += $urandom_range(0, 50);
            else if (pick < 62)
                stim_ms += $urandom_range(0, 32'(talk_len));
            else if (pick < 70)
                // around the warning edge, counted from the talk start
                stim_ms += ((window < talk_len) ? talk_len - window : window)
                           + $urandom_range(0, 2) - 1;
            else if (pick < 78)
                stim_ms += phase_ms(tbpt_pkg::phase_t'(2'($urandom_range(0, 2))))
                           * $urandom_range(1, 300);
            else if (pick < 84)
            begin
                back = $urandom_range(0, 32'(talk_len));
                stim_ms = (stim_ms > back) ? stim_ms - back : '0;
            end
            else if (pick < 88)
                stim_ms = NOW_MAX - $urandom_range(0, 32'(talk_len) * 2);
            else if (pick < 91)
                stim_ms = {16'($urandom), 32'($urandom)};
            else if (pick < 93)
                stim_ms = $urandom_range(0, 10);
            else
                stim_ms += 1;
            c.now = stim_ms;
            cmd_backlog.push_back(c);
        end
    endtask

    task automatic run_random(input int n);
        queue_random_words(n);
        wait_idle();
    endtask

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset config: 10 min talks, 60 s warning, 3 s alarm, no break
        push_cmd(tbpt_pkg::OP_TICK, '0);                  // idle session ignores everything
        push_cmd(tbpt_pkg::OP_NEXT, 48'd5);
        push_cmd(tbpt_pkg::OP_PAUSE, 48'd5);
        push_cmd(tbpt_pkg::OP_START, 48'd1000);           // talk 0 ends at 601000
        push_cmd(tbpt_pkg::OP_TICK, 48'd540999);          // one ms outside the warning
        push_cmd(tbpt_pkg::OP_TICK, 48'd541000);          // warning edge
        push_cmd(tbpt_pkg::OP_PAUSE, 48'd541000);
        push_cmd(tbpt_pkg::OP_TICK, 48'd700000);          // held: no advance
        push_cmd(tbpt_pkg::OP_PAUSE, 48'd700000);         // second pause is a no-op
        push_cmd(tbpt_pkg::OP_RESUME, 48'd600000);        // end slides to 660000
        push_cmd(tbpt_pkg::OP_RESUME, 48'd600000);
        push_cmd(tbpt_pkg::OP_TICK, 48'd660000);          // into alarm
        push_cmd(tbpt_pkg::OP_TICK, 48'd663000);          // alarm over, talk 1
        push_cmd(tbpt_pkg::OP_NEXT, 48'd700000);
        push_cmd(tbpt_pkg::OP_PREVIOUS, 48'd700001);
        push_cmd(tbpt_pkg::OP_RESTART, 48'd700002);
        push_cmd(tbpt_pkg::OP_TICK, NOW_MAX);             // catch up to the session end
        push_cmd(tbpt_pkg::OP_START, NOW_MAX - 48'd4095); // phase end pinned at the top
        push_cmd(tbpt_pkg::OP_TICK, '0);                  // remaining clamps at 24 bits
        push_cmd(tbpt_pkg::OP_PAUSE, 48'd100);
        push_cmd(tbpt_pkg::OP_RESUME, 48'd50);            // clock went backwards while held
        push_cmd(tbpt_pkg::OP_PREVIOUS, 48'd300);         // talk 0 just restarts
        push_cmd(tbpt_pkg::OP_NEXT, 48'd400);
        push_cmd(tbpt_pkg::OP_STOP, 48'd500);
        push_cmd(tbpt_pkg::OP_RESTART, 48'd600);
        wait_idle();

        run_random(PHASE_WORDS);
        set_config(3, 1, 30, 10, 500);
        run_random(PHASE_WORDS);
        set_config(255, 255, 4095, 4095, 65535);
        run_random(PHASE_WORDS);
        set_config(255, 1, 0, 0, 0);            // long session, zero alarm: catch-up cap
        run_random(PHASE_WORDS);
        set_config(0, 0, 0, 0, 0);              // every phase zero, every talk the last
        run_random(PHASE_WORDS);
        set_config(4, 1, 60, 5, 100);           // window equals the talk: no warning
        run_random(PHASE_WORDS);
        set_config(2, 2, 119, 1, 1);
        run_random(PHASE_WORDS);

        // unused index must leave the registers alone
        write_reg(tbpt_pkg::CFG_IDX_W'($urandom_range(tbpt_pkg::REG_ALARM_MS + 1,
                                                      (1 << tbpt_pkg::CFG_IDX_W) - 1)),
                  tbpt_pkg::CFG_DATA_W'($urandom));
        repeat (3)
        begin
            set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
            run_random(PHASE_WORDS);
        end

        wait_idle();
        repeat (CATCH_LIMIT + 20) @(posedge clk);
        if (err_count == 0)
            $display("[talk_break_phase_timer] OK");
        else
            $display("[talk_break_phase_timer] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tbpt_pkg.sv
rtl/tbpt_ctrl.sv
rtl/tbpt_dp.sv
rtl/talk_break_phase_timer.sv
rtl/tbpt_chk.sv
test/tb_talk_break_phase_timer.sv
